// ----- rtl/core/mpe_pkg.sv -----
// Shared types, codes and helpers for the execute block.
package mpe_pkg;

  localparam int REG_COUNT_DEF  = 256;
  localparam int DATA_WORDS_DEF = 1024;
  localparam int PC_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [7:0] OP_HALT     = 8'h00;
  localparam logic [7:0] OP_ADD      = 8'h01;
  localparam logic [7:0] OP_SUB      = 8'h02;
  localparam logic [7:0] OP_MUL      = 8'h03;
  localparam logic [7:0] OP_UDIV     = 8'h04;
  localparam logic [7:0] OP_LOAD     = 8'h05;
  localparam logic [7:0] OP_STORE    = 8'h06;
  localparam logic [7:0] OP_MOVE_S1  = 8'h07;
  localparam logic [7:0] OP_ADDI     = 8'h09;
  localparam logic [7:0] OP_SUBI     = 8'h0A;
  localparam logic [7:0] OP_MULI     = 8'h0B;
  localparam logic [7:0] OP_UDIVI    = 8'h0C;
  localparam logic [7:0] OP_LOADI    = 8'h0D;
  localparam logic [7:0] OP_STOREI   = 8'h0E;
  localparam logic [7:0] OP_MOVE_S2  = 8'h0F;
  localparam logic [7:0] OP_BR_FIRST = 8'h10;
  localparam logic [7:0] OP_BR_LAST  = 8'h1E;

  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef enum logic [3:0] {
    CL_HALT, CL_ADD, CL_SUB, CL_MUL, CL_DIV, CL_LOAD, CL_STORE, CL_MOVE,
    CL_BRANCH, CL_INVALID
  } op_class_e;

  typedef enum logic [3:0] {
    CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
    CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_AL
  } cond_e;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_DIV, S_LOAD, S_DONE
  } back_state_e;

  typedef struct packed {
    logic [7:0] op_code;
    logic [7:0] dest_field;
    logic [7:0] first_source;
    logic [7:0] second_source;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [1:0]  status;
    logic        reg_write;
    logic [7:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [31:0] mem_value;
    logic        flag_zero;
    logic        flag_negative;
    logic        flag_carry;
    logic        flag_overflow;
  } result_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  // Decoded word; register indices already reduced to the register count
  typedef struct packed {
    op_class_e  cls;
    logic       imm;
    cond_e      cond;
    logic [7:0] dest;
    logic [7:0] src1;
    logic [7:0] src2;
  } dec_t;

  typedef struct packed {
    logic clearing;
    logic res_valid;
  } back_out_t;

  function automatic logic cond_holds(cond_e c, flags_t f);
    logic r;
    case (c)
      CC_EQ:   r = f.z;
      CC_NE:   r = !f.z;
      CC_CS:   r = f.c;
      CC_CC:   r = !f.c;
      CC_MI:   r = f.n;
      CC_PL:   r = !f.n;
      CC_VS:   r = f.v;
      CC_VC:   r = !f.v;
      CC_HI:   r = f.c && !f.z;
      CC_LS:   r = !f.c || f.z;
      CC_GE:   r = (f.n == f.v);
      CC_LT:   r = (f.n != f.v);
      CC_GT:   r = !f.z && (f.n == f.v);
      CC_LE:   r = f.z || (f.n != f.v);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/mpe_front.sv -----
// Front end: takes instruction words, classifies them and reduces register indices.
module mpe_front #(
  parameter int REG_COUNT = mpe_pkg::REG_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  mpe_pkg::instr_t instr_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output mpe_pkg::dec_t  q_item_o,
  output logic           busy_o
);
  import mpe_pkg::*;

  logic  valid_q, valid_d;
  dec_t  item_q;
  dec_t  dec;

  // Register count must lie in 16..256 (the block does not enforce it), so four conditional subtracts suffice
  function automatic logic [7:0] rmod(logic [7:0] f);
    logic [12:0] r;
    r = 13'(f);
    for (int k = 3; k >= 0; k--) begin
      if (r >= 13'(REG_COUNT << k)) begin
        r = r - 13'(REG_COUNT << k);
      end
    end
    return r[7:0];
  endfunction

  always_comb begin
    dec.imm  = instr_i.op_code[3];
    dec.cond = cond_e'(instr_i.op_code[3:0]);
    dec.dest = rmod(instr_i.dest_field);
    dec.src1 = rmod(instr_i.first_source);
    dec.src2 = instr_i.second_source;
    case (instr_i.op_code)
      OP_HALT:                dec.cls = CL_HALT;
      OP_ADD, OP_ADDI:        dec.cls = CL_ADD;
      OP_SUB, OP_SUBI:        dec.cls = CL_SUB;
      OP_MUL, OP_MULI:        dec.cls = CL_MUL;
      OP_UDIV, OP_UDIVI:      dec.cls = CL_DIV;
      OP_LOAD, OP_LOADI:      dec.cls = CL_LOAD;
      OP_STORE, OP_STOREI:    dec.cls = CL_STORE;
      OP_MOVE_S1, OP_MOVE_S2: dec.cls = CL_MOVE;
      default: begin
        if (instr_i.op_code inside {[OP_BR_FIRST:OP_BR_LAST]}) begin
          dec.cls = CL_BRANCH;
        end else begin
          dec.cls = CL_INVALID;
        end
      end
    endcase
    // Register operand for the second source; immediate forms and branches keep the raw byte
    if (!dec.imm && dec.cls != CL_BRANCH) begin
      dec.src2 = rmod(instr_i.second_source);
    end
    // Move of the first source byte keeps it raw
    if (instr_i.op_code == OP_MOVE_S1) begin
      dec.src1 = instr_i.first_source;
    end
  end

  assign q_push_o = valid_q && !q_full_i;
  assign q_item_o = item_q;
  assign busy_o   = valid_q && q_full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= dec;
    end
  end

endmodule

// ----- rtl/core/mpe_queue.sv -----
// Short queue of decoded words between front and back.
module mpe_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mpe_pkg::dec_t item_i,
  output logic          full_o,
  input  logic          pop_i,
  output mpe_pkg::dec_t item_o,
  output logic          empty_o
);
  import mpe_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  dec_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/core/mpe_divider.sv -----
// Restoring unsigned divider, one quotient bit a cycle.
module mpe_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] quotient_o
);
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic [32:0] shifted, trial;
  logic        fits;

  assign shifted = {rem_q, quo_q[31]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[31:0] : shifted[31:0];
      quo_q <= {quo_q[30:0], fits};
    end
  end

endmodule

// ----- rtl/core/mpe_back.sv -----
// Back end: register file, data store, flags and program counter; executes words.
module mpe_back #(
  parameter int REG_COUNT  = mpe_pkg::REG_COUNT_DEF,
  parameter int DATA_WORDS = mpe_pkg::DATA_WORDS_DEF,
  parameter int PC_BITS    = mpe_pkg::PC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  mpe_pkg::dec_t      q_item_i,
  output logic               q_pop_o,
  input  logic               res_ready_i,
  output mpe_pkg::back_out_t bk_o,
  output mpe_pkg::result_t   result_o
);
  import mpe_pkg::*;

  localparam int RIDX_W  = $clog2(REG_COUNT);
  localparam int DADDR_W = $clog2(DATA_WORDS);

  logic [31:0]          rf [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_q;
  logic [31:0]          dm [DATA_WORDS];

  back_state_e         state_q, state_d;
  dec_t                it_q;
  logic [31:0]         ra_q, rb_q, dm_rd_q;
  logic                va_q, vb_q;
  logic [PC_BITS-1:0]  pc_q;
  flags_t              flags_q;
  logic                halted_q;
  logic [1:0]          stop_q;
  logic                rw_q, mw_q;
  logic [31:0]         rv_q, maddr_q, mval_q;
  logic [DADDR_W-1:0]  clr_q;
  logic                mod_busy_q, mod_done_q;
  logic [2:0]          mod_cnt_q;
  logic [17:0]         mod_rem_q;
  logic [31:0]         mod_src_q;

  logic [RIDX_W-1:0]   ra_addr, rb_addr, wr_addr;
  logic [31:0]         opa, regb, opb, diff, mem_addr;
  logic [32:0]         sum;
  logic [PC_BITS-1:0]  pc_inc, pc_br, br_off;
  logic                exec_div, cond_ok;
  logic                div_start, div_busy, div_done;
  logic                mod_start, unit_done;
  logic [31:0]         div_quo;
  logic                dm_we, rf_we;
  logic [DADDR_W-1:0]  dm_addr;
  logic [31:0]         dm_wdata;

  // Four address bits a cycle, most significant first
  function automatic logic [17:0] mod_step(logic [17:0] r, logic [3:0] bits);
    logic [17:0] x;
    x = r;
    for (int j = 3; j >= 0; j--) begin
      x = {x[16:0], bits[j]};
      if (x >= 18'(DATA_WORDS)) begin
        x = x - 18'(DATA_WORDS);
      end
    end
    return x;
  endfunction

  assign ra_addr  = q_item_i.src1[RIDX_W-1:0];
  assign rb_addr  = (q_item_i.cls == CL_STORE) ? q_item_i.dest[RIDX_W-1:0]
                                               : q_item_i.src2[RIDX_W-1:0];
  assign wr_addr  = it_q.dest[RIDX_W-1:0];

  assign opa      = va_q ? ra_q : '0;
  assign regb     = vb_q ? rb_q : '0;
  assign opb      = it_q.imm ? 32'(it_q.src2) : regb;
  assign sum      = 33'(opa) + 33'(opb);
  assign diff     = opa - opb;
  // Only the immediate load takes its address from the word; stores use the register
  assign mem_addr = (it_q.imm && it_q.cls == CL_LOAD) ? 32'(it_q.src2) : opa;
  assign pc_inc   = pc_q + PC_BITS'(4);
  assign br_off   = PC_BITS'($signed(it_q.src2));
  assign pc_br    = pc_q + (br_off << 2);
  assign cond_ok  = cond_holds(it_q.cond, flags_q);
  assign exec_div = !halted_q && ((it_q.cls == CL_LOAD) || (it_q.cls == CL_STORE) ||
                                  ((it_q.cls == CL_DIV) && (opb != '0)));
  assign unit_done = (it_q.cls == CL_DIV) ? div_done : mod_done_q;

  mpe_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (opa),
    .divisor_i   (opb),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == DADDR_W'(DATA_WORDS - 1)) state_d = S_IDLE;
      S_IDLE:  if (!q_empty_i) state_d = S_EXEC;
      S_EXEC:  state_d = exec_div ? S_DIV : S_DONE;
      S_DIV: begin
        if (unit_done) begin
          state_d = (it_q.cls == CL_LOAD) ? S_LOAD : S_DONE;
        end
      end
      S_LOAD:  state_d = S_DONE;
      S_DONE:  if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    q_pop_o          = (state_q == S_IDLE) && !q_empty_i;
    div_start        = (state_q == S_EXEC) && exec_div && (it_q.cls == CL_DIV);
    mod_start        = (state_q == S_EXEC) && exec_div && (it_q.cls != CL_DIV);
    bk_o.clearing    = (state_q == S_CLEAR);
    bk_o.res_valid   = (state_q == S_DONE);
    rf_we            = (state_q == S_DONE) && res_ready_i && rw_q;
    dm_we            = 1'b0;
    dm_addr          = mod_rem_q[DADDR_W-1:0];
    dm_wdata         = mval_q;
    case (state_q)
      S_CLEAR: begin
        dm_we    = 1'b1;
        dm_addr  = clr_q;
        dm_wdata = '0;
      end
      S_DIV:   dm_we = mod_done_q && (it_q.cls == CL_STORE);
      default: dm_we = 1'b0;
    endcase
  end

  always_comb begin
    result_o.next_pc       = 16'(pc_q);
    result_o.status        = stop_q;
    result_o.reg_write     = rw_q;
    result_o.reg_index     = rw_q ? it_q.dest : '0;
    result_o.reg_value     = rv_q;
    result_o.mem_write     = mw_q;
    result_o.mem_address   = maddr_q;
    result_o.mem_value     = mval_q;
    result_o.flag_zero     = flags_q.z;
    result_o.flag_negative = flags_q.n;
    result_o.flag_carry    = flags_q.c;
    result_o.flag_overflow = flags_q.v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      pc_q     <= '0;
      flags_q  <= '0;
      halted_q <= 1'b0;
      stop_q   <= ST_RUN;
      rf_vld_q <= '0;
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      va_q    <= rf_vld_q[ra_addr];
      vb_q    <= rf_vld_q[rb_addr];
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (rf_we) begin
        rf_vld_q[wr_addr] <= 1'b1;
      end
      if (state_q == S_EXEC && !halted_q) begin
        pc_q <= pc_inc;
        case (it_q.cls)
          CL_HALT: begin
            halted_q <= 1'b1;
            stop_q   <= ST_HALT;
          end
          CL_ADD: begin
            flags_q.n <= sum[31];
            flags_q.z <= (sum[31:0] == '0);
            flags_q.c <= sum[32];
            flags_q.v <= ~(opa[31] ^ opb[31]) & (opa[31] ^ sum[31]);
          end
          CL_SUB: begin
            flags_q.n <= diff[31];
            flags_q.z <= (diff == '0);
            flags_q.c <= (opa >= opb);
            flags_q.v <= (opa[31] ^ opb[31]) & (opa[31] ^ diff[31]);
          end
          CL_DIV: begin
            if (opb == '0) begin
              halted_q <= 1'b1;
              stop_q   <= ST_DIVZERO;
            end
          end
          CL_BRANCH: if (cond_ok) pc_q <= pc_br;
          CL_INVALID: begin
            halted_q <= 1'b1;
            stop_q   <= ST_INVALID;
          end
          default: ;
        endcase
      end
    end
  end

  // Data address reduction modulo the store size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_busy_q <= 1'b0;
      mod_done_q <= 1'b0;
      mod_cnt_q  <= '0;
    end else begin
      mod_done_q <= 1'b0;
      if (mod_start) begin
        mod_busy_q <= 1'b1;
        mod_cnt_q  <= '0;
      end else if (mod_busy_q) begin
        mod_cnt_q <= mod_cnt_q + 1'b1;
        if (mod_cnt_q == 3'd7) begin
          mod_busy_q <= 1'b0;
          mod_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mod_start) begin
      mod_rem_q <= '0;
      mod_src_q <= mem_addr;
    end else if (mod_busy_q) begin
      mod_rem_q <= mod_step(mod_rem_q, mod_src_q[31:28]);
      mod_src_q <= {mod_src_q[27:0], 4'h0};
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it_q <= q_item_i;
    end
    if (state_q == S_EXEC) begin
      rw_q    <= 1'b0;
      mw_q    <= 1'b0;
      rv_q    <= '0;
      maddr_q <= '0;
      mval_q  <= '0;
      if (!halted_q) begin
        case (it_q.cls)
          CL_ADD: begin
            rw_q <= 1'b1;
            rv_q <= sum[31:0];
          end
          CL_SUB: begin
            rw_q <= 1'b1;
            rv_q <= diff;
          end
          CL_MUL: begin
            rw_q <= 1'b1;
            rv_q <= opa * opb;
          end
          CL_DIV:  rw_q <= (opb != '0);
          CL_LOAD: begin
            rw_q    <= 1'b1;
            maddr_q <= mem_addr;
          end
          CL_STORE: begin
            mw_q    <= 1'b1;
            maddr_q <= mem_addr;
            mval_q  <= it_q.imm ? 32'(it_q.src2) : regb;
          end
          CL_MOVE: begin
            rw_q <= 1'b1;
            rv_q <= it_q.imm ? 32'(it_q.src2) : 32'(it_q.src1);
          end
          default: ;
        endcase
      end
    end else if (state_q == S_DIV && div_done && it_q.cls == CL_DIV) begin
      rv_q <= div_quo;
    end else if (state_q == S_LOAD) begin
      rv_q <= dm_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= rf[ra_addr];
    rb_q <= rf[rb_addr];
    if (rf_we) begin
      rf[wr_addr] <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dm_rd_q <= dm[dm_addr];
    if (dm_we) begin
      dm[dm_addr] <= dm_wdata;
    end
  end

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted mark cleared");
  a_no_write_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && halted_q) |=> (!rw_q && !mw_q))
    else $error("write reported after stop");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_ready_i) |=> (state_q == S_DONE && $stable(rv_q)))
    else $error("pending result changed");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !q_pop_o)
    else $error("word taken during clearing pass");
`endif

endmodule

// ----- rtl/core/mini_processor_execute.sv -----
// Top level of the execute block: front end, queue, back end and result register.
//
//   channel   | ports                        | word
//   ----------+------------------------------+-----------------------------
//   input     | push, full, instr_i          | one four-byte instruction
//   result    | empty, pop, result_o         | one step result
//
// A word passes from the front end through the queue to the back end, which
// executes moves, arithmetic other than divide, branches and stops without a
// unit, divide in the bit-serial divider, and store and load once their data
// address is reduced modulo DATA_WORDS four bits a cycle; a load then reads.
// After reset a clearing pass zeroes every word of the data store; full stays
// high meanwhile. The queue and the result register absorb short stalls on
// either side; a long stall on the result side fills them and raises full.
module mini_processor_execute #(
  parameter int REG_COUNT  = mpe_pkg::REG_COUNT_DEF,
  parameter int DATA_WORDS = mpe_pkg::DATA_WORDS_DEF,
  parameter int PC_BITS    = mpe_pkg::PC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  mpe_pkg::instr_t  instr_i,
  output logic             empty,
  input  logic             pop,
  output mpe_pkg::result_t result_o
);
  import mpe_pkg::*;

  logic      accept, fe_busy, fe_push, q_full, q_empty, q_pop;
  dec_t      fe_item, q_item;
  back_out_t bk;
  result_t   bk_res, ob_q;
  logic      ob_valid_q, res_ready;

  assign full      = bk.clearing || fe_busy;
  assign accept    = push && !full;
  assign res_ready = !ob_valid_q;
  assign empty     = !ob_valid_q;
  assign result_o  = ob_q;

  mpe_front #(.REG_COUNT(REG_COUNT)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .instr_i  (instr_i),
    .q_full_i (q_full),
    .q_push_o (fe_push),
    .q_item_o (fe_item),
    .busy_o   (fe_busy)
  );

  mpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .item_i  (fe_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  mpe_back #(
    .REG_COUNT  (REG_COUNT),
    .DATA_WORDS (DATA_WORDS),
    .PC_BITS    (PC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_ready_i (res_ready),
    .bk_o        (bk),
    .result_o    (bk_res)
  );

  // Hold the finished word until it is popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_valid_q <= 1'b0;
    end else if (bk.res_valid && res_ready) begin
      ob_valid_q <= 1'b1;
    end else if (pop) begin
      ob_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bk.res_valid && res_ready) begin
      ob_q <= bk_res;
    end
  end

endmodule

// ----- verif/mini_processor_execute_tb.sv -----
// Self-checking testbench for mini_processor_execute: directed table, random words, stop.
`timescale 1ns / 100ps

module mini_processor_execute_tb;
  import mpe_pkg::*;

  localparam logic [7:0] OP_UNUSED = 8'h08;
  localparam int RANDOM_WORDS = 1930;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    instr_t  word;
    bit      fixed;
    result_t res;
  } table_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    push;
  logic    full;
  instr_t  instr_i;
  logic    empty;
  logic    pop;
  result_t result_o;

  // Predicted machine state
  logic [31:0] regs [256];
  logic [31:0] dmem [1024];
  logic [15:0] pc;
  logic        fz, fn, fc, fv;
  logic        stopped;
  logic [1:0]  stop_code;

  result_t    pending_results [$];
  table_row_t dir_rows [$];
  int         mismatch_count;
  int         results_seen;
  bit         quiet_tx;
  bit         quiet_rx;

  mini_processor_execute DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .instr_i  (instr_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic result_t make_result(logic [15:0] npc, logic [1:0] st, logic rw,
                                          logic [7:0] ri, logic [31:0] rv, logic mw,
                                          logic [31:0] ma, logic [31:0] mv,
                                          logic z, logic n, logic c, logic v);
    result_t r;
    r = '{npc, st, rw, ri, rv, mw, ma, mv, z, n, c, v};
    return r;
  endfunction

  function automatic logic branch_taken(cond_e c);
    logic t;
    case (c)
      CC_EQ:   t = fz;
      CC_NE:   t = !fz;
      CC_CS:   t = fc;
      CC_CC:   t = !fc;
      CC_MI:   t = fn;
      CC_PL:   t = !fn;
      CC_VS:   t = fv;
      CC_VC:   t = !fv;
      CC_HI:   t = fc && !fz;
      CC_LS:   t = !fc || fz;
      CC_GE:   t = (fn == fv);
      CC_LT:   t = (fn != fv);
      CC_GT:   t = !fz && (fn == fv);
      CC_LE:   t = fz || (fn != fv);
      default: t = 1'b1;
    endcase
    return t;
  endfunction

  function automatic logic [31:0] add_flags(logic [31:0] a, logic [31:0] b, logic sub);
    logic [31:0] r;
    r  = sub ? a - b : a + b;
    fz = (r == 32'd0);
    fn = r[31];
    fc = sub ? (a >= b) : (r < a);
    fv = sub ? ((a[31] ^ b[31]) & (a[31] ^ r[31])) : (~(a[31] ^ b[31]) & (a[31] ^ r[31]));
    return r;
  endfunction

  // Advance the predicted machine by one word and return its result
  function automatic result_t execute_word(instr_t w);
    result_t     r;
    logic [15:0] cur;
    logic [31:0] a, b;
    logic        imm;
    r   = '0;
    imm = w.op_code[3];
    if (!stopped) begin
      cur = pc;
      pc  = cur + 16'd4;
      a   = regs[w.first_source];
      b   = imm ? {24'd0, w.second_source} : regs[w.second_source];
      case (w.op_code)
        OP_HALT: begin
          stopped = 1'b1; stop_code = ST_HALT;
        end
        OP_ADD, OP_ADDI: begin
          r.reg_write = 1'b1; r.reg_value = add_flags(a, b, 1'b0);
        end
        OP_SUB, OP_SUBI: begin
          r.reg_write = 1'b1; r.reg_value = add_flags(a, b, 1'b1);
        end
        OP_MUL, OP_MULI: begin
          r.reg_write = 1'b1; r.reg_value = a * b;
        end
        OP_UDIV, OP_UDIVI: begin
          if (b == 32'd0) begin
            stopped = 1'b1; stop_code = ST_DIVZERO;
          end else begin
            r.reg_write = 1'b1; r.reg_value = a / b;
          end
        end
        OP_LOAD, OP_LOADI: begin
          r.mem_address = imm ? {24'd0, w.second_source} : a;
          r.reg_write   = 1'b1;
          r.reg_value   = dmem[r.mem_address[9:0]];
        end
        OP_STORE, OP_STOREI: begin
          r.mem_address = a;
          r.mem_write   = 1'b1;
          r.mem_value   = imm ? {24'd0, w.second_source} : regs[w.dest_field];
        end
        OP_MOVE_S1: begin
          r.reg_write = 1'b1; r.reg_value = {24'd0, w.first_source};
        end
        OP_MOVE_S2: begin
          r.reg_write = 1'b1; r.reg_value = {24'd0, w.second_source};
        end
        default: begin
          if (w.op_code >= OP_BR_FIRST && w.op_code <= OP_BR_LAST) begin
            if (branch_taken(cond_e'(4'(w.op_code - OP_BR_FIRST))))
              pc = cur + {{6{w.second_source[7]}}, w.second_source, 2'b00};
          end else begin
            stopped = 1'b1; stop_code = ST_INVALID;
          end
        end
      endcase
      if (r.reg_write) begin
        r.reg_index = w.dest_field;
        regs[w.dest_field] = r.reg_value;
      end
      if (r.mem_write) dmem[r.mem_address[9:0]] = r.mem_value;
    end
    r.next_pc       = pc;
    r.status        = stop_code;
    r.flag_zero     = fz;
    r.flag_negative = fn;
    r.flag_carry    = fc;
    r.flag_overflow = fv;
    return r;
  endfunction

  function automatic logic [7:0] pick_reg();
    return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
  endfunction

  // Well-formed running word: never stops the machine
  function automatic instr_t random_word();
    instr_t w;
    w.op_code       = 8'($urandom_range(OP_ADD, OP_BR_LAST));
    if (w.op_code == OP_UNUSED) w.op_code = OP_MOVE_S1;
    w.dest_field    = pick_reg();
    w.first_source  = $urandom_range(0, 1) ? pick_reg() : 8'($urandom_range(0, 255));
    w.second_source = $urandom_range(0, 1) ? pick_reg() : 8'($urandom_range(0, 255));
    if (w.op_code == OP_UDIV && regs[w.second_source] == 32'd0) w.op_code = OP_UDIVI;
    if (w.op_code == OP_UDIVI && w.second_source == 8'd0)
      w.second_source = 8'($urandom_range(1, 255));
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 40) $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Offer one word, then predict it once the block has taken it
  task automatic send_word(instr_t w, bit fixed, result_t fixed_res);
    int      gap;
    result_t p;
    gap = quiet_tx ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_i <= w;
    push    <= 1'b1;
    do @(posedge clk_i); while (full);
    p = execute_word(w);
    pending_results.push_back(fixed ? fixed_res : p);
  endtask

  // Result side: random stalls, one long hold-off to back up the input
  initial begin
    int  gap;
    bit  held;
    held = 1'b0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = quiet_rx ? 0 : $urandom_range(0, 13);
      if (!held && results_seen >= HOLD_AT) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", result_o.next_pc, want.next_pc);
        check_field("status", result_o.status, want.status);
        check_field("reg_write", result_o.reg_write, want.reg_write);
        check_field("reg_index", result_o.reg_index, want.reg_index);
        check_field("reg_value", result_o.reg_value, want.reg_value);
        check_field("mem_write", result_o.mem_write, want.mem_write);
        check_field("mem_address", result_o.mem_address, want.mem_address);
        check_field("mem_value", result_o.mem_value, want.mem_value);
        check_field("flag_zero", result_o.flag_zero, want.flag_zero);
        check_field("flag_negative", result_o.flag_negative, want.flag_negative);
        check_field("flag_carry", result_o.flag_carry, want.flag_carry);
        check_field("flag_overflow", result_o.flag_overflow, want.flag_overflow);
      end
    end
  end

  initial begin
    instr_t  w;
    result_t none;
    int      wait_cycles;
    none           = '0;
    mismatch_count = 0;
    results_seen   = 0;
    quiet_tx       = 1'b0;
    quiet_rx       = 1'b0;
    foreach (regs[i]) regs[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    pc = '0; fz = 0; fn = 0; fc = 0; fv = 0;
    stopped = 1'b0; stop_code = ST_RUN;
    rst_ni  <= 1'b0;
    push    <= 1'b0;
    instr_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    dir_rows.push_back('{'{OP_MOVE_S1, 8'd1, 8'hFF, 8'd0}, 1,
      make_result(16'd4, ST_RUN, 1, 8'd1, 32'hFF, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{'{OP_MOVE_S2, 8'd2, 8'd0, 8'h80}, 1,
      make_result(16'd8, ST_RUN, 1, 8'd2, 32'h80, 0, 0, 0, 0, 0, 0, 0)});
    // cleared store reads back zero
    dir_rows.push_back('{'{OP_LOADI, 8'd3, 8'd0, 8'hFF}, 1,
      make_result(16'd12, ST_RUN, 1, 8'd3, 32'd0, 0, 32'hFF, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{'{OP_ADD, 8'd4, 8'd1, 8'd2}, 0, none});
    // borrow clears carry
    dir_rows.push_back('{'{OP_SUBI, 8'd5, 8'd0, 8'd1}, 1,
      make_result(16'd20, ST_RUN, 1, 8'd5, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 0, 0)});
    dir_rows.push_back('{'{OP_ADDI, 8'd6, 8'd5, 8'd1}, 1,
      make_result(16'd24, ST_RUN, 1, 8'd6, 32'd0, 0, 0, 0, 1, 0, 1, 0)});
    dir_rows.push_back('{'{OP_MULI, 8'd7, 8'd5, 8'hFF}, 0, none});
    dir_rows.push_back('{'{OP_SUB, 8'd8, 8'd2, 8'd2}, 0, none});
    dir_rows.push_back('{'{OP_MUL, 8'd10, 8'd2, 8'd2}, 0, none});
    dir_rows.push_back('{'{OP_MUL, 8'd11, 8'd10, 8'd10}, 0, none});
    dir_rows.push_back('{'{OP_MULI, 8'd12, 8'd11, 8'd8}, 0, none});
    dir_rows.push_back('{'{OP_ADD, 8'd13, 8'd12, 8'd12}, 0, none});
    dir_rows.push_back('{'{OP_SUBI, 8'd14, 8'd12, 8'd1}, 0, none});
    dir_rows.push_back('{'{OP_SUB, 8'd19, 8'd0, 8'd12}, 0, none});
    dir_rows.push_back('{'{OP_UDIV, 8'd15, 8'd5, 8'd1}, 0, none});
    dir_rows.push_back('{'{OP_UDIVI, 8'd16, 8'd5, 8'hFF}, 0, none});
    dir_rows.push_back('{'{OP_STORE, 8'd5, 8'd1, 8'd0}, 0, none});
    dir_rows.push_back('{'{OP_STOREI, 8'd0, 8'd12, 8'hAA}, 0, none});
    dir_rows.push_back('{'{OP_LOAD, 8'd17, 8'd1, 8'd0}, 0, none});
    dir_rows.push_back('{'{OP_LOAD, 8'd18, 8'd12, 8'd0}, 0, none});
    dir_rows.push_back('{'{OP_MOVE_S1, 8'hFF, 8'h00, 8'hFF}, 0, none});
    dir_rows.push_back('{'{8'(OP_BR_FIRST + CC_VS), 8'd0, 8'd0, 8'h80}, 0, none});
    dir_rows.push_back('{'{8'(OP_BR_FIRST + CC_EQ), 8'd0, 8'd0, 8'h7F}, 0, none});
    dir_rows.push_back('{'{8'(OP_BR_FIRST + CC_LT), 8'd0, 8'd0, 8'hFE}, 0, none});
    dir_rows.push_back('{'{8'(OP_BR_FIRST + CC_AL), 8'hFF, 8'hFF, 8'h01}, 0, none});

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].res);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 64 == 0) begin
        quiet_tx = ($urandom_range(0, 3) == 0);
        quiet_rx = ($urandom_range(0, 3) == 0);
      end
      send_word(random_word(), 0, none);
    end

    // stop the machine one way, then check that later words change nothing
    w = random_word();
    case ($urandom_range(0, 2))
      0: w.op_code = OP_HALT;
      1: begin
        w.op_code = OP_UDIVI; w.second_source = 8'd0;
      end
      default: w.op_code = $urandom_range(0, 1) ? OP_UNUSED : 8'($urandom_range(8'h1F, 8'hFF));
    endcase
    send_word(w, 0, none);
    repeat (12) send_word(instr_t'($urandom()), 0, none);
    push <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200_000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
